### rtl/core/epoch_seconds_to_calendar_defines.svh
// Assertion macros for the epoch seconds to calendar block.
// Used by the port checker; no other dependencies.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// same-cycle implication, off during reset
`define EPSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("epsc assertion failed");

// next-cycle implication, off during reset
`define EPSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("epsc assertion failed");

// next-cycle implication, always on
`define EPSC_ASSERT_NXT_ALW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("epsc assertion failed");

`endif

### rtl/core/epsc_pkg.sv
// Package for the epoch seconds to calendar block: widths, item type,
// reciprocal constants and month start tables. No dependencies.
`default_nettype none

package epsc_pkg;

    localparam int SECS_W    = 32;
    localparam int OFFSET_W  = 11;
    localparam int OFF60_W   = 18;
    localparam int LOCAL_W   = 34;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [LOCAL_W-1:0] LOCAL_LIMIT = 34'd4102444800;

    // seconds per day = 2^7 * 675
    localparam int DAY_SHIFT = 7;
    localparam int DAYQ_W    = SECS_W - DAY_SHIFT;
    localparam logic [25:0] DAY_RECIP = 26'd50903316;   // floor(2^35/675)
    localparam int DAY_RSHIFT = 35;
    localparam int DAY_PROD_W = DAYQ_W + 26;
    localparam logic [9:0] DAY_DIV = 10'd675;

    localparam logic [17:0] MIN_RECIP  = 18'd139811;    // ceil(2^23/60)
    localparam int          MIN_RSHIFT = 23;
    localparam logic [10:0] HOUR_RECIP = 11'd1093;      // ceil(2^16/60)
    localparam int          HOUR_RSHIFT = 16;
    localparam logic [15:0] QUAD_RECIP = 16'd45934;     // ceil(2^26/1461)
    localparam int          QUAD_RSHIFT = 26;
    localparam logic [16:0] WEEK_RECIP = 17'd74899;     // ceil(2^19/7)
    localparam int          WEEK_RSHIFT = 19;

    localparam int DAYS_PER_QUAD = 1461;
    localparam int SIXTY         = 60;
    localparam int WEEK_LEN      = 7;
    localparam int EPOCH_WDAY    = 4;
    localparam int EPOCH_YEAR    = 1970;
    localparam int YEAR_LEN      = 365;

    localparam logic [8:0] MSTART_COMMON [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] MSTART_LEAP [13] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    typedef struct packed {
        logic              range_error;
        logic [SECS_W-1:0] local_secs;
    } t_job;

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] v;
        v = '0;
        if (idx <= 4'd12) begin
            v = leap ? MSTART_LEAP[idx] : MSTART_COMMON[idx];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/epsc_in_if.sv
// Input channel of the epoch seconds to calendar block: valid/ready
// plus the seconds count. No dependencies.
`default_nettype none

interface epsc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

`default_nettype wire

### rtl/core/epsc_out_if.sv
// Result channel of the epoch seconds to calendar block: valid/ready
// plus the calendar fields. No dependencies.
`default_nettype none

interface epsc_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
    logic [4:0]  hour_24;
    logic [3:0]  hour_12;
    logic        is_pm;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        range_error;

    modport source (output valid, output year, output month, output mday,
                    output day_of_year, output weekday, output hour_24, output hour_12,
                    output is_pm, output minute, output second, output range_error,
                    input ready);
    modport sink   (input valid, input year, input month, input mday,
                    input day_of_year, input weekday, input hour_24, input hour_12,
                    input is_pm, input minute, input second, input range_error,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/epoch_seconds_to_calendar.sv
// Top level: UNIX seconds plus zone offset to calendar date and time.
// Depends on epsc_pkg, epsc_in_if, epsc_out_if, epsc_front, epsc_queue, epsc_back.
//
//   channel   dir  handshake      payload
//   i_in      in   valid/ready    unix_seconds (32 b)
//   o_out     out  valid/ready    year .. range_error (11 fields)
//   i_cfg_*   in   write enable   zone_offset_minutes (11 b signed)
//
// One item per cycle sustained while the output is not stalled; a result
// passes from the queue, written at its input accept edge, through
// back-end stages 1 to 7, stage 7 being the output register. Synchronous
// active-low reset clears the zone offset to 0 and empties the queue and
// pipeline. A stalled output freezes the back end; the queue then fills and
// drops i_in.ready.
`default_nettype none

module epoch_seconds_to_calendar (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [epsc_pkg::OFFSET_W-1:0] i_cfg_wdata,
    epsc_in_if.sink                       i_in,
    epsc_out_if.source                    o_out
);
    import epsc_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    epsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    epsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    epsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

### rtl/core/epsc_front.sv
// Front end: zone offset register, local time and range classification.
// Depends on epsc_pkg and epsc_in_if.
`default_nettype none

module epsc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [epsc_pkg::OFFSET_W-1:0]    i_cfg_wdata,
    epsc_in_if.sink                          i_in,
    input  logic                             i_q_full,
    output logic                             o_push,
    output epsc_pkg::t_job                   o_job
);
    import epsc_pkg::*;

    logic [OFFSET_W-1:0] r_zone;
    logic [OFF60_W-1:0]  off_ext;
    logic [OFF60_W-1:0]  off60;
    logic [LOCAL_W-1:0]  loc_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    always_comb begin
        off_ext  = {{(OFF60_W-OFFSET_W){r_zone[OFFSET_W-1]}}, r_zone};
        // minutes * 60 = m*64 - m*4
        off60    = (off_ext << 6) - (off_ext << 2);
        loc_secs = {{(LOCAL_W-SECS_W){1'b0}}, i_in.unix_seconds}
                 + {{(LOCAL_W-OFF60_W){off60[OFF60_W-1]}}, off60};
        o_job.range_error = loc_secs[LOCAL_W-1] || (loc_secs >= LOCAL_LIMIT);
        o_job.local_secs  = loc_secs[SECS_W-1:0];
    end

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

endmodule

`default_nettype wire

### rtl/core/epsc_queue.sv
// Short item queue between front and back end.
// Depends on epsc_pkg.
`default_nettype none

module epsc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  epsc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output epsc_pkg::t_job o_job
);
    import epsc_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/epsc_back.sv
// Back end: seven-stage calendar pipeline with reciprocal division.
// Depends on epsc_pkg and epsc_out_if.
`default_nettype none

module epsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  epsc_pkg::t_job i_q_job,
    output logic           o_pop,
    epsc_out_if.source     o_out
);
    import epsc_pkg::*;

    localparam int NSTG = 7;

    logic [NSTG:1] r_vld;
    logic          en;

    // stage 1: day quotient product
    logic                  r_s1_err;
    logic [DAYQ_W-1:0]     r_s1_q;
    logic [DAY_SHIFT-1:0]  r_s1_lo;
    logic [DAY_PROD_W-1:0] r_s1_prod;
    // stage 2: estimate and raw remainder
    logic                  r_s2_err;
    logic [15:0]           r_s2_est;
    logic [10:0]           r_s2_rem;
    logic [DAY_SHIFT-1:0]  r_s2_lo;
    // stage 3: days and second of day
    logic                  r_s3_err;
    logic [15:0]           r_s3_days;
    logic [16:0]           r_s3_sod;
    // stage 4: quotients
    logic                  r_s4_err;
    logic [15:0]           r_s4_days;
    logic [16:0]           r_s4_dp4;
    logic [16:0]           r_s4_sod;
    logic [10:0]           r_s4_mtot;
    logic [5:0]            r_s4_quad;
    logic [12:0]           r_s4_wq;
    // stage 5: remainders and hour quotient
    logic                  r_s5_err;
    logic [10:0]           r_s5_mtot;
    logic [5:0]            r_s5_quad;
    logic [4:0]            r_s5_hour;
    logic [5:0]            r_s5_sec;
    logic [10:0]           r_s5_rem;
    logic [2:0]            r_s5_wk;
    // stage 6: year split and minute
    logic                  r_s6_err;
    logic [4:0]            r_s6_hour;
    logic [5:0]            r_s6_sec;
    logic [5:0]            r_s6_min;
    logic [2:0]            r_s6_wk;
    logic [11:0]           r_s6_year;
    logic                  r_s6_leap;
    logic [8:0]            r_s6_rem;
    // stage 7: output register
    logic [11:0]           r_year;
    logic [3:0]            r_month;
    logic [4:0]            r_dom;
    logic [8:0]            r_doy;
    logic [2:0]            r_wk;
    logic [4:0]            r_h24;
    logic [3:0]            r_h12;
    logic                  r_pm;
    logic [5:0]            r_min;
    logic [5:0]            r_sec;
    logic                  r_err;

    logic [15:0]           s2_est;
    logic [10:0]           s3_rem;
    logic [15:0]           s3_days;
    logic [16:0]           s4_dp4;
    logic [1:0]            s6_yoff;
    logic [8:0]            s6_rem;
    logic [3:0]            s7_mon;
    logic [3:0]            s7_h12;

    assign en    = !r_vld[NSTG] || o_out.ready;
    assign o_pop = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-1:1], i_q_valid};
        end
    end

    always_comb begin
        s2_est = r_s1_prod[DAY_PROD_W-1:DAY_RSHIFT];
        if (r_s2_rem >= 11'(DAY_DIV)) begin
            s3_rem  = r_s2_rem - 11'(DAY_DIV);
            s3_days = r_s2_est + 16'd1;
        end else begin
            s3_rem  = r_s2_rem;
            s3_days = r_s2_est;
        end
        s4_dp4 = 17'(r_s3_days) + 17'(EPOCH_WDAY);
    end

    always_comb begin
        priority if (r_s5_rem < 11'(YEAR_LEN)) begin
            s6_yoff = 2'd0;
            s6_rem  = 9'(r_s5_rem);
        end else if (r_s5_rem < 11'(2*YEAR_LEN)) begin
            s6_yoff = 2'd1;
            s6_rem  = 9'(r_s5_rem - 11'(YEAR_LEN));
        end else if (r_s5_rem < 11'(3*YEAR_LEN+1)) begin
            s6_yoff = 2'd2;
            s6_rem  = 9'(r_s5_rem - 11'(2*YEAR_LEN));
        end else begin
            s6_yoff = 2'd3;
            s6_rem  = 9'(r_s5_rem - 11'(3*YEAR_LEN+1));
        end
    end

    always_comb begin
        s7_mon = 4'd1;
        for (int k = 1; k < 12; k++) begin
            if (r_s6_rem >= month_start(r_s6_leap, 4'(k))) begin
                s7_mon = 4'(k + 1);
            end
        end
        priority if (r_s6_hour == 5'd0) begin
            s7_h12 = 4'd12;
        end else if (r_s6_hour > 5'd12) begin
            s7_h12 = 4'(r_s6_hour - 5'd12);
        end else begin
            s7_h12 = 4'(r_s6_hour);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_err  <= i_q_job.range_error;
            r_s1_q    <= i_q_job.local_secs[SECS_W-1:DAY_SHIFT];
            r_s1_lo   <= i_q_job.local_secs[DAY_SHIFT-1:0];
            r_s1_prod <= DAY_PROD_W'(i_q_job.local_secs[SECS_W-1:DAY_SHIFT])
                       * DAY_PROD_W'(DAY_RECIP);

            r_s2_err  <= r_s1_err;
            r_s2_est  <= s2_est;
            r_s2_rem  <= 11'(r_s1_q - DAYQ_W'(s2_est) * DAYQ_W'(DAY_DIV));
            r_s2_lo   <= r_s1_lo;

            r_s3_err  <= r_s2_err;
            r_s3_days <= s3_days;
            r_s3_sod  <= {s3_rem[9:0], r_s2_lo};

            r_s4_err  <= r_s3_err;
            r_s4_days <= r_s3_days;
            r_s4_dp4  <= s4_dp4;
            r_s4_sod  <= r_s3_sod;
            r_s4_mtot <= 11'((35'(r_s3_sod) * 35'(MIN_RECIP)) >> MIN_RSHIFT);
            r_s4_quad <= 6'((32'(r_s3_days) * 32'(QUAD_RECIP)) >> QUAD_RSHIFT);
            r_s4_wq   <= 13'((34'(s4_dp4) * 34'(WEEK_RECIP)) >> WEEK_RSHIFT);

            r_s5_err  <= r_s4_err;
            r_s5_mtot <= r_s4_mtot;
            r_s5_quad <= r_s4_quad;
            r_s5_hour <= 5'((22'(r_s4_mtot) * 22'(HOUR_RECIP)) >> HOUR_RSHIFT);
            r_s5_sec  <= 6'(r_s4_sod - 17'(r_s4_mtot) * 17'(SIXTY));
            r_s5_rem  <= 11'(r_s4_days - 16'(r_s4_quad) * 16'(DAYS_PER_QUAD));
            r_s5_wk   <= 3'(r_s4_dp4 - 17'(r_s4_wq) * 17'(WEEK_LEN));

            r_s6_err  <= r_s5_err;
            r_s6_hour <= r_s5_hour;
            r_s6_sec  <= r_s5_sec;
            r_s6_min  <= 6'(r_s5_mtot - 11'(r_s5_hour) * 11'(SIXTY));
            r_s6_wk   <= r_s5_wk;
            r_s6_year <= 12'(EPOCH_YEAR) + 12'({r_s5_quad, s6_yoff});
            r_s6_leap <= (s6_yoff == 2'd2);
            r_s6_rem  <= s6_rem;

            r_err <= r_s6_err;
            if (r_s6_err) begin
                r_year  <= '0;
                r_month <= '0;
                r_dom   <= '0;
                r_doy   <= '0;
                r_wk    <= '0;
                r_h24   <= '0;
                r_h12   <= '0;
                r_pm    <= 1'b0;
                r_min   <= '0;
                r_sec   <= '0;
            end else begin
                r_year  <= r_s6_year;
                r_month <= s7_mon;
                r_dom   <= 5'(r_s6_rem - month_start(r_s6_leap, s7_mon - 4'd1) + 9'd1);
                r_doy   <= r_s6_rem + 9'd1;
                r_wk    <= r_s6_wk;
                r_h24   <= r_s6_hour;
                r_h12   <= s7_h12;
                r_pm    <= (r_s6_hour >= 5'd12);
                r_min   <= r_s6_min;
                r_sec   <= r_s6_sec;
            end
        end
    end

    assign o_out.valid        = r_vld[NSTG];
    assign o_out.year         = r_year;
    assign o_out.month        = r_month;
    assign o_out.mday         = r_dom;
    assign o_out.day_of_year  = r_doy;
    assign o_out.weekday      = r_wk;
    assign o_out.hour_24      = r_h24;
    assign o_out.hour_12      = r_h12;
    assign o_out.is_pm        = r_pm;
    assign o_out.minute       = r_min;
    assign o_out.second       = r_sec;
    assign o_out.range_error  = r_err;

endmodule

`default_nettype wire

### rtl/core/epsc_checker.sv
// Port-level checker for epoch_seconds_to_calendar, with its bind.
// Depends on epsc_pkg and epoch_seconds_to_calendar_defines.svh.
`default_nettype none
`include "epoch_seconds_to_calendar_defines.svh"

module epsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_year,
    input logic [3:0]  i_month,
    input logic [4:0]  i_mday,
    input logic [8:0]  i_day_of_year,
    input logic [2:0]  i_weekday,
    input logic [4:0]  i_hour_24,
    input logic [3:0]  i_hour_12,
    input logic        i_is_pm,
    input logic        i_range_error
);
    import epsc_pkg::*;

    logic        out_stalled;
    logic        err_fields_zero;
    logic        fields_in_range;
    logic [26:0] held;

    assign out_stalled     = i_out_valid && !i_out_ready;
    assign err_fields_zero = (i_year == '0) && (i_month == '0) && (i_mday == '0)
                          && (i_weekday == '0) && (i_hour_12 == '0) && !i_is_pm;
    assign fields_in_range = (i_year >= 12'(EPOCH_YEAR))
                          && (i_month >= 4'd1) && (i_month <= 4'd12)
                          && (i_mday >= 5'd1) && (i_day_of_year >= 9'd1)
                          && (i_hour_12 >= 4'd1) && (i_hour_12 <= 4'd12)
                          && (i_is_pm == (i_hour_24 >= 5'd12));
    assign held            = {i_year, i_day_of_year, i_hour_24, i_range_error};

    `EPSC_ASSERT_NXT_ALW(a_rst_no_valid, i_clk, !i_rst_n, !i_out_valid)

    `EPSC_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, out_stalled, i_out_valid && $stable(held))

    `EPSC_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_out_valid && i_range_error, err_fields_zero)

    `EPSC_ASSERT_IMP(a_fields_sane, i_clk, i_rst_n, i_out_valid && !i_range_error, fields_in_range)

endmodule

bind epoch_seconds_to_calendar epsc_checker u_epsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_year         (o_out.year),
    .i_month        (o_out.month),
    .i_mday         (o_out.mday),
    .i_day_of_year  (o_out.day_of_year),
    .i_weekday      (o_out.weekday),
    .i_hour_24      (o_out.hour_24),
    .i_hour_12      (o_out.hour_12),
    .i_is_pm        (o_out.is_pm),
    .i_range_error  (o_out.range_error)
);

`default_nettype wire
